FILE: rtl/rcbp_pkg.sv
// ============================================================================
// rcbp_pkg
// Shared types, constants and constant tables of the LED ring chase and
// breath pattern core.
// ============================================================================
package rcbp_pkg;

    // Default sizes for the top-level parameters.
    localparam int RING_LEDS_DEF    = 16;
    localparam int SINE_ENTRIES_DEF = 256;

    // Ring positions travel at the width of the largest ring (64 pixels).
    localparam int POS_W = 6;

    // Breath period in milliseconds.
    localparam int BREATH_PERIOD_MS = 4800;

    // Reciprocal of 75 in 2^-33 units, rounded down. It is used on now_ms[31:6].
    localparam int RECIP75_SHIFT = 33;
    localparam logic [26:0] RECIP75 = 27'((64'd1 << RECIP75_SHIFT) / 64'd75);

    // Chase thresholds on the closeness level.
    localparam logic [7:0] CHASE_MIN_LEVEL = 8'd5;
    localparam logic [7:0] TRAIL3_LEVEL    = 8'd140;

    // Sine constants in Q30 for the breath table.
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;

    // Color choice codes.
    localparam int ECHO_W = 2;
    localparam logic [ECHO_W-1:0] ECHO_YELLOW = 2'd0;
    localparam logic [ECHO_W-1:0] ECHO_PINK   = 2'd1;
    localparam logic [ECHO_W-1:0] ECHO_BLUE   = 2'd2;

    // Input word of one tick.
    typedef struct packed {
        logic [31:0] now_ms;
        logic        sleep_active;
        logic        dock_latched;
        logic [7:0]  closeness_level;
    } tick_word_t;

    // Output word of one pixel.
    typedef struct packed {
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pixel_word_t;

    // Base color.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // What the pixel emitter needs to draw one tick.
    typedef struct packed {
        logic             dock_on;
        logic             chase_on;
        logic [7:0]       level;
        logic [POS_W-1:0] head;
        logic [POS_W-1:0] prev1;
        logic [POS_W-1:0] prev2;
        logic             trail3;
        logic [7:0]       sc0;
        logic [7:0]       sc1;
        logic [7:0]       sc2;
    } tick_desc_t;

    typedef logic [8:0] step_tab_t [256];
    typedef logic [7:0] level_tab_t [256];

    // Chase step period in ms for each closeness level.
    function automatic step_tab_t build_step_table();
        step_tab_t t;
        int        v;
        for (int l = 0; l < 256; l++)
        begin
            v = (76500 - 210 * l) / 255;
            if (v < 40)
                v = 40;
            t[l] = 9'(v);
        end
        return t;
    endfunction

    // Head pixel level: peak times 255.
    function automatic level_tab_t build_head_table();
        level_tab_t t;
        int         v;
        for (int l = 0; l < 256; l++)
        begin
            v = (14025 + 45 * l) / 100;
            if (v > 255)
                v = 255;
            t[l] = 8'(v);
        end
        return t;
    endfunction

    // First trail pixel: 0.42 of the peak.
    function automatic level_tab_t build_mid_table();
        level_tab_t t;
        int         v;
        for (int l = 0; l < 256; l++)
        begin
            v = ((14025 + 45 * l) * 42) / 10000;
            if (v > 255)
                v = 255;
            t[l] = 8'(v);
        end
        return t;
    endfunction

    // Second trail pixel: 0.18 of the peak.
    function automatic level_tab_t build_tail_table();
        level_tab_t t;
        int         v;
        for (int l = 0; l < 256; l++)
        begin
            v = ((14025 + 45 * l) * 18) / 10000;
            if (v > 255)
                v = 255;
            t[l] = 8'(v);
        end
        return t;
    endfunction

    localparam step_tab_t  STEP_TABLE = build_step_table();
    localparam level_tab_t HEAD_TABLE = build_head_table();
    localparam level_tab_t MID_TABLE  = build_mid_table();
    localparam level_tab_t TAIL_TABLE = build_tail_table();

    // Base color for each color code; the unused code gives yellow.
    function automatic rgb_t color_of(input logic [ECHO_W-1:0] code);
        rgb_t c;
        case (code)
            ECHO_PINK: c = '{r: 8'd255, g: 8'd80, b: 8'd140};
            ECHO_BLUE: c = '{r: 8'd60, g: 8'd120, b: 8'd255};
            default:   c = '{r: 8'd255, g: 8'd200, b: 8'd0};
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/rcbp_rom.sv
// ============================================================================
// rcbp_rom
// Breath level ROM: one sine period of levels, built at elaboration, read
// with a registered output.
// ============================================================================
module rcbp_rom #(
    parameter int SINE_ENTRIES = rcbp_pkg::SINE_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [$clog2(SINE_ENTRIES)-1:0] addr,
    output logic [7:0]                      data
);
    import rcbp_pkg::*;

    typedef logic [7:0] rom_t [SINE_ENTRIES];

    // sin(pi/2 * r / SINE_ENTRIES) in Q30 by an odd series up to x^11.
    function automatic logic signed [63:0] quarter_sine(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x = (HALF_PI_Q30 * r) / 64'(SINE_ENTRIES);
        term = x;
        sum = signed'(x);
        for (int n = 1; n <= 5; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if ((n & 1) != 0)
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return sum;
    endfunction

    // Full period by quadrant folding; level = 140.25 + 114.75 * sin.
    function automatic rom_t build_rom();
        rom_t               t;
        logic [63:0]        q4;
        logic [63:0]        quad;
        logic [63:0]        rem;
        logic signed [63:0] s;
        logic signed [63:0] num;
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            q4   = 64'(4 * k);
            quad = q4 / 64'(SINE_ENTRIES);
            rem  = q4 % 64'(SINE_ENTRIES);
            if (quad[0])
                s = quarter_sine(64'(SINE_ENTRIES) - rem);
            else
                s = quarter_sine(rem);
            if (quad >= 64'd2)
                s = -s;
            num  = 64'sd561 * ONE_Q30 + 64'sd459 * s;
            t[k] = num[39:32];
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [7:0] data_reg;

    // Registered read.
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

FILE: rtl/rcbp_tick.sv
// ============================================================================
// rcbp_tick
// Six-stage tick pipeline: chase divider (now_ms / step, modulo the ring),
// breath phase and ROM read, and the per-tick draw description.
// ============================================================================
module rcbp_tick #(
    parameter int RING_LEDS    = rcbp_pkg::RING_LEDS_DEF,
    parameter int SINE_ENTRIES = rcbp_pkg::SINE_ENTRIES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rcbp_pkg::tick_word_t   tick_word,
    output rcbp_pkg::tick_desc_t   desc,
    output logic                   desc_valid,
    input  logic                   take
);
    import rcbp_pkg::*;

    localparam int HW      = $clog2(RING_LEDS);
    localparam int AW      = $clog2(SINE_ENTRIES);
    localparam int NSTAGE  = 6;
    localparam int K_SHIFT = 24;
    // SINE_ENTRIES / 4800 in 2^-24 units, rounded down.
    localparam longint unsigned K_MUL =
        (longint'(SINE_ENTRIES) << K_SHIFT) / longint'(BREATH_PERIOD_MS);

    typedef struct packed {
        logic [31:0]   now;
        logic          sleep;
        logic          dock;
        logic [7:0]    lvl;
        logic [8:0]    step;
        logic [8:0]    drem;
        logic [HW-1:0] head;
        logic [52:0]   prod75;
        logic [12:0]   phase;
        logic [36:0]   kprod;
        logic [AW-1:0] k;
        logic          trail3;
        logic [7:0]    sc0;
        logic [7:0]    sc1;
        logic [7:0]    sc2;
    } stage_t;

    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] valid_next;
    logic [NSTAGE:1] can_load;
    stage_t          stage_reg  [1:NSTAGE];
    stage_t          stage_next [1:NSTAGE];
    logic [7:0]      breath_level;

    // Eight restoring division steps on one dividend byte. Each quotient bit
    // also updates the quotient modulo the ring size.
    function automatic stage_t div_byte(input stage_t st, input logic [7:0] bits);
        stage_t      o;
        logic [9:0]  r;
        logic [HW:0] h2;
        logic        qb;
        o = st;
        for (int i = 0; i < 8; i++)
        begin
            r  = {o.drem, bits[7-i]};
            qb = (r >= {1'b0, o.step});
            if (qb)
                r = r - {1'b0, o.step};
            o.drem = r[8:0];
            h2 = {o.head, qb};
            if (h2 >= (HW+1)'(RING_LEDS))
                h2 = h2 - (HW+1)'(RING_LEDS);
            o.head = h2[HW-1:0];
        end
        return o;
    endfunction

    // Stall chain: a stage loads when it is empty or its word moves on.
    always_comb
    begin
        can_load[NSTAGE] = !valid_reg[NSTAGE] || take;
        for (int k = NSTAGE - 1; k >= 1; k--)
            can_load[k] = !valid_reg[k] || can_load[k+1];
    end

    assign busy = !can_load[1];

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load[1])
            valid_next[1] = start;
        for (int k = 2; k <= NSTAGE; k++)
        begin
            if (can_load[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    // Stage logic.
    always_comb
    begin
        logic [19:0] q75;
        logic [26:0] r75;
        logic [12:0] kest;
        logic [31:0] lhs;
        logic [31:0] rhs;

        // Stage 1: capture the word and look up the chase step.
        stage_next[1]       = '0;
        stage_next[1].now   = tick_word.now_ms;
        stage_next[1].sleep = tick_word.sleep_active;
        stage_next[1].dock  = tick_word.dock_latched;
        stage_next[1].lvl   = tick_word.closeness_level;
        stage_next[1].step  = STEP_TABLE[tick_word.closeness_level];

        // Stage 2: quotient bits 31..24, reciprocal product for mod 4800, levels.
        stage_next[2] = div_byte(stage_reg[1], stage_reg[1].now[31:24]);
        stage_next[2].prod75 = 53'(stage_reg[1].now[31:6]) * 53'(RECIP75);
        stage_next[2].sc0    = HEAD_TABLE[stage_reg[1].lvl];
        stage_next[2].sc1    = MID_TABLE[stage_reg[1].lvl];
        stage_next[2].sc2    = TAIL_TABLE[stage_reg[1].lvl];
        stage_next[2].trail3 = (stage_reg[1].lvl > TRAIL3_LEVEL);

        // Stage 3: bits 23..16; phase = now mod 4800 from (now >> 6) mod 75.
        stage_next[3] = div_byte(stage_reg[2], stage_reg[2].now[23:16]);
        q75 = stage_reg[2].prod75[RECIP75_SHIFT +: 20];
        r75 = 27'(stage_reg[2].now[31:6]) - 27'(q75) * 27'd75;
        if (r75 >= 27'd75)
            r75 = r75 - 27'd75;
        stage_next[3].phase = {r75[6:0], stage_reg[2].now[5:0]};

        // Stage 4: bits 15..8; estimate of the table index.
        stage_next[4] = div_byte(stage_reg[3], stage_reg[3].now[15:8]);
        stage_next[4].kprod = 37'(stage_reg[3].phase) * 37'(K_MUL);

        // Stage 5: bits 7..0; the estimate is at most one low, correct it.
        stage_next[5] = div_byte(stage_reg[4], stage_reg[4].now[7:0]);
        kest = stage_reg[4].kprod[K_SHIFT +: 13];
        lhs  = 32'(stage_reg[4].phase) * 32'(SINE_ENTRIES);
        rhs  = (32'(kest) + 32'd1) * 32'(BREATH_PERIOD_MS);
        if (lhs >= rhs)
            kest = kest + 13'd1;
        stage_next[5].k = AW'(kest);

        // Stage 6: the ROM read runs alongside.
        stage_next[6] = stage_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 1; k <= NSTAGE; k++)
        begin
            if (can_load[k])
                stage_reg[k] <= stage_next[k];
        end
    end

    rcbp_rom #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_rom (
        .clk  (clk),
        .en   (can_load[NSTAGE]),
        .addr (stage_reg[NSTAGE-1].k),
        .data (breath_level)
    );

    // Draw description of the oldest tick.
    always_comb
    begin
        logic [HW-1:0] h;
        logic [HW-1:0] p1;
        logic [HW-1:0] p2;
        h  = stage_reg[NSTAGE].head;
        p1 = (h == '0) ? HW'(RING_LEDS - 1) : h - HW'(1);
        p2 = (p1 == '0) ? HW'(RING_LEDS - 1) : p1 - HW'(1);
        desc.dock_on  = !stage_reg[NSTAGE].sleep && stage_reg[NSTAGE].dock;
        desc.chase_on = !stage_reg[NSTAGE].sleep && !stage_reg[NSTAGE].dock
                        && (stage_reg[NSTAGE].lvl > CHASE_MIN_LEVEL);
        desc.level    = breath_level;
        desc.head     = POS_W'(h);
        desc.prev1    = POS_W'(p1);
        desc.prev2    = POS_W'(p2);
        desc.trail3   = stage_reg[NSTAGE].trail3;
        desc.sc0      = stage_reg[NSTAGE].sc0;
        desc.sc1      = stage_reg[NSTAGE].sc1;
        desc.sc2      = stage_reg[NSTAGE].sc2;
    end

    assign desc_valid = valid_reg[NSTAGE];

`ifndef NO_ASSERTIONS
    // A tick waiting for the emitter keeps its whole state.
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTAGE] && !take |=> valid_reg[NSTAGE] && $stable(stage_reg[NSTAGE]))
        else $error("waiting tick changed in the last stage");

    // The breath phase is below the period.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> stage_reg[3].phase < 13'(BREATH_PERIOD_MS))
        else $error("breath phase out of range");

    // The chase head lies on the ring.
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSTAGE] |-> (HW+1)'(stage_reg[NSTAGE].head) < (HW+1)'(RING_LEDS))
        else $error("chase head off the ring");

    // The pipeline only holds off new words when its first stage is full.
    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> valid_reg[1])
        else $error("busy with an empty first stage");
`endif

endmodule

FILE: rtl/rcbp_pixel.sv
// ============================================================================
// rcbp_pixel
// Pixel emitter: walks the ring one pixel per cycle for each tick, picks the
// pixel level, and scales the base color in a registered output stage.
// ============================================================================
module rcbp_pixel #(
    parameter int RING_LEDS = rcbp_pkg::RING_LEDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcbp_pkg::tick_desc_t          desc,
    input  logic                          desc_valid,
    output logic                          take,
    input  logic [rcbp_pkg::ECHO_W-1:0]   echo_type,
    output logic                          pixel_strobe,
    output rcbp_pkg::pixel_word_t         pixel_word
);
    import rcbp_pkg::*;

    localparam int HW = $clog2(RING_LEDS);
    localparam logic [HW-1:0] LAST_POS = HW'(RING_LEDS - 1);

    logic          act_reg;
    logic          act_next;
    logic [HW-1:0] cnt_reg;
    logic [HW-1:0] cnt_next;
    tick_desc_t    cur_reg;
    logic          at_last;

    logic          p_valid_reg;
    logic [3:0]    p_index_reg;
    logic          p_last_reg;
    logic [7:0]    p_scale_reg;
    logic [7:0]    scale_next;

    logic          strobe_reg;
    pixel_word_t   word_reg;
    pixel_word_t   word_next;
    rgb_t          base;

    // c * s / 255, exact for 8-bit operands.
    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(c) * 16'(s);
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    // A new tick loads when the emitter is idle or on the last pixel.
    assign at_last = (cnt_reg == LAST_POS);
    assign take    = desc_valid && (!act_reg || at_last);

    always_comb
    begin
        act_next = act_reg;
        cnt_next = cnt_reg;
        if (take)
        begin
            act_next = 1'b1;
            cnt_next = '0;
        end
        else if (act_reg)
        begin
            if (at_last)
                act_next = 1'b0;
            else
                cnt_next = cnt_reg + HW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            act_reg <= act_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= desc;
    end

    // Level of the current pixel.
    always_comb
    begin
        logic [POS_W-1:0] pos;
        pos = POS_W'(cnt_reg);
        scale_next = 8'd0;
        if (cur_reg.dock_on)
            scale_next = cur_reg.level;
        else if (cur_reg.chase_on)
        begin
            if (pos == cur_reg.head)
                scale_next = cur_reg.sc0;
            else if (pos == cur_reg.prev1)
                scale_next = cur_reg.sc1;
            else if (cur_reg.trail3 && pos == cur_reg.prev2)
                scale_next = cur_reg.sc2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= act_reg;
    end

    always_ff @(posedge clk)
    begin
        p_index_reg <= 4'(cnt_reg);
        p_last_reg  <= at_last;
        p_scale_reg <= scale_next;
    end

    // Output stage: scale the base color.
    assign base = color_of(echo_type);

    always_comb
    begin
        word_next.pixel_index = p_index_reg;
        word_next.red         = scale_channel(base.r, p_scale_reg);
        word_next.green       = scale_channel(base.g, p_scale_reg);
        word_next.blue        = scale_channel(base.b, p_scale_reg);
        word_next.last_pixel  = p_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign pixel_strobe = strobe_reg;
    assign pixel_word   = word_reg;

`ifndef NO_ASSERTIONS
    // Pixels of one tick come in consecutive cycles in ring order.
    a_pixel_run: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && !pixel_word.last_pixel |=> pixel_strobe
            && pixel_word.pixel_index == $past(pixel_word.pixel_index) + 4'd1)
        else $error("pixel run broken");

    // The last pixel of a tick is the last ring position.
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && pixel_word.last_pixel |-> pixel_word.pixel_index == 4'(RING_LEDS - 1))
        else $error("last pixel at the wrong position");

    // A dark pixel is black on every channel.
    a_dark_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg && p_scale_reg == 8'd0 |=> pixel_word.red == 8'd0
            && pixel_word.green == 8'd0 && pixel_word.blue == 8'd0)
        else $error("dark pixel has color");
`endif

endmodule

FILE: rtl/led_ring_chase_breath_pattern_core.sv
// ============================================================================
// led_ring_chase_breath_pattern_core
// LED ring pattern generator: sleep, breathing dock animation and a
// closeness-driven chase, one color word per ring pixel for every tick.
// ============================================================================
// Usage:
// - Tick channel: a tick word (time, sleep, dock, closeness) is taken at a
//   rising edge with start high and busy low.
// - Pixel channel: each tick gives RING_LEDS pixel words, pixel 0 first, one
//   per cycle, each shown for one cycle with pixel_strobe high; the last one
//   carries last_pixel. The receiver cannot hold words off.
// - Configuration: cfg_we writes cfg_data into the color choice register;
//   write it only while no tick is in flight.
// - Path: with no tick ahead of it, a tick passes the tick pipeline stages,
//   the emitter's tick register, its pixel registers and the output register
//   before pixel 0 is on the ports. The emitter draws one pixel per cycle
//   and takes a waiting tick on the last pixel. Ahead of it a six-stage
//   pipeline (chase divider eight quotient bits per stage, breath phase, ROM
//   read) holds up to six ticks; busy rises when it is full and none is taken.
// - Reset: all pipeline and emitter words are dropped and the color choice
//   returns to yellow. No clearing pass is needed.
// ============================================================================
module led_ring_chase_breath_pattern_core #(
    parameter int RING_LEDS    = rcbp_pkg::RING_LEDS_DEF,
    parameter int SINE_ENTRIES = rcbp_pkg::SINE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rcbp_pkg::tick_word_t          tick_word,
    input  logic                          cfg_we,
    input  logic [rcbp_pkg::ECHO_W-1:0]   cfg_data,
    output logic                          pixel_strobe,
    output rcbp_pkg::pixel_word_t         pixel_word
);
    import rcbp_pkg::*;

    logic [ECHO_W-1:0] echo_type_reg;
    tick_desc_t        desc;
    logic              desc_valid;
    logic              take;

    // Color choice register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            echo_type_reg <= ECHO_YELLOW;
        else if (cfg_we)
            echo_type_reg <= cfg_data;
    end

    // Tick pipeline.
    rcbp_tick #(
        .RING_LEDS    (RING_LEDS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_tick (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .tick_word  (tick_word),
        .desc       (desc),
        .desc_valid (desc_valid),
        .take       (take)
    );

    // Pixel emitter.
    rcbp_pixel #(
        .RING_LEDS (RING_LEDS)
    ) u_pixel (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc         (desc),
        .desc_valid   (desc_valid),
        .take         (take),
        .echo_type    (echo_type_reg),
        .pixel_strobe (pixel_strobe),
        .pixel_word   (pixel_word)
    );

endmodule
